@@ hdl/assert_macros.svh @@
// assertion macros shared by the console cursor engine rtl
// depends on nothing; each macro expects a signal named clock and a signal named reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, switched off while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked on the following clock edge
`define ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

@@ hdl/tcce_pkg.sv @@
// shared types, constants and helpers for the text console cursor engine
// no dependencies; used by text_console_cursor_engine
`default_nettype none

package tcce_pkg;

   // grid limits
   localparam int MaxRows     = 32;
   localparam int MaxColumns  = 256;
   localparam int TableDepth  = 32;
   localparam int RowLimit    = (MaxRows < TableDepth) ? MaxRows : TableDepth;
   localparam int ResultSlots = 4;

   // field widths
   localparam int CharWidth     = 8;
   localparam int ColumnWidth   = 8;
   localparam int RowWidth      = 5;
   localparam int GlyphWidth    = 7;
   localparam int RowsCfgWidth  = 6;
   localparam int CsrDataWidth  = 8;
   localparam int CsrIndexWidth = 1;
   localparam int SlotIdxWidth  = $clog2(ResultSlots);
   localparam int SlotCntWidth  = $clog2(ResultSlots + 1);

   // register reset values
   localparam logic [ColumnWidth-1:0]  ColumnsReset = 8'd160;
   localparam logic [RowsCfgWidth-1:0] RowsReset    = 6'd25;

   // character codes
   localparam logic [CharWidth-1:0]  CharLf      = 8'd10;
   localparam logic [CharWidth-1:0]  CharCr      = 8'd13;
   localparam logic [CharWidth-1:0]  CharSpace   = 8'd32;
   localparam logic [CharWidth-1:0]  CharTilde   = 8'd126;
   localparam logic [CharWidth-1:0]  CharDelete  = 8'd127;
   localparam logic [GlyphWidth-1:0] CursorGlyph = 7'd95;

   typedef enum logic [1:0] {
      CmdErase  = 2'd0,
      CmdDraw   = 2'd1,
      CmdScroll = 2'd2,
      CmdError  = 2'd3
   } command_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      RegColumns = 1'b0,
      RegRows    = 1'b1
   } csr_index_type;

   typedef struct packed {
      command_type            command;
      logic [ColumnWidth-1:0] column;
      logic [RowWidth-1:0]    row;
      logic [GlyphWidth-1:0]  glyph;
   } result_type;

   function automatic result_type make_result(input command_type            cmd,
                                              input logic [ColumnWidth-1:0] col,
                                              input logic [RowWidth-1:0]    row,
                                              input logic [GlyphWidth-1:0]  glyph);
      result_type r;
      r.command = cmd;
      r.column  = col;
      r.row     = row;
      r.glyph   = glyph;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/text_console_cursor_engine.sv @@
// Flow: a byte is taken into the input register and moves on to the result register once
// that is free; the result register then offers the first cell command of the byte.
// Throughput: with rsp_ready high, one byte per cycle while each gives at most one command;
// a byte holds the result port until its commands (up to four) are taken, one per cycle.
// Reset clears cursor, the 32-entry line length table and the halt flag at once, and loads
// 160 columns and 25 rows; a byte that halts the block blocks further output until reset.
// depends on tcce_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module text_console_cursor_engine (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // byte transactions in
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [tcce_pkg::CharWidth-1:0]       req_char_code,
   input  wire logic                                 req_first_of_string,
   input  wire logic                                 req_last_of_string,
   // cell command transactions out
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [1:0]                                rsp_command,
   output logic [tcce_pkg::ColumnWidth-1:0]          rsp_column,
   output logic [tcce_pkg::RowWidth-1:0]             rsp_row,
   output logic [tcce_pkg::GlyphWidth-1:0]           rsp_glyph,
   output logic                                      rsp_last_result,
   // register writes
   input  wire logic                                 csr_write_enable,
   input  wire logic [tcce_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [tcce_pkg::CsrDataWidth-1:0]    csr_write_data
);

   localparam int ColW = tcce_pkg::ColumnWidth;
   localparam int RowW = tcce_pkg::RowWidth;

   // configuration registers
   logic [ColW-1:0]                       columns_in_use_ff;
   logic [tcce_pkg::RowsCfgWidth-1:0]     rows_in_use_ff;

   // input register
   logic                                  in_valid_ff, in_valid_in;
   logic [tcce_pkg::CharWidth-1:0]        in_char_ff;
   logic                                  in_first_ff;
   logic                                  in_last_ff;

   // console state
   logic [ColW-1:0]                       cursor_column_ff, cursor_column_in;
   logic [RowW-1:0]                       cursor_row_ff, cursor_row_in;
   logic [ColW-1:0]                       line_length_ff [tcce_pkg::TableDepth];
   logic [ColW-1:0]                       line_length_in [tcce_pkg::TableDepth];
   logic                                  halted_ff, halted_in;

   // result register
   logic                                  rsp_valid_ff;
   tcce_pkg::result_type                  rsp_list_ff [tcce_pkg::ResultSlots];
   logic [tcce_pkg::SlotIdxWidth-1:0]     rsp_idx_ff;
   logic [tcce_pkg::SlotIdxWidth-1:0]     rsp_last_ff;

   // per-byte work
   tcce_pkg::result_type                  list_in [tcce_pkg::ResultSlots];
   logic [tcce_pkg::SlotCntWidth-1:0]     count_in;
   logic [ColW-1:0]                       table_mid [tcce_pkg::TableDepth];
   logic                                  scroll;
   logic [tcce_pkg::RowsCfgWidth-1:0]     rows_eff;
   logic [RowW-1:0]                       rows_m1;
   logic [ColW:0]                         cols_eff;
   logic                                  wrap;
   logic                                  nl_scroll;
   logic [RowW-1:0]                       nl_row;
   logic [RowW-1:0]                       prev_row;
   logic                                  batch_free;
   logic                                  move;
   logic                                  rsp_take;

   // handshake
   assign rsp_take   = rsp_valid_ff && rsp_ready;
   assign batch_free = !rsp_valid_ff || (rsp_ready && (rsp_idx_ff == rsp_last_ff));
   assign move       = in_valid_ff && batch_free;
   assign req_ready  = !in_valid_ff || move;

   // effective grid size
   always_comb begin
      rows_eff = rows_in_use_ff;
      if (rows_eff == '0) begin
         rows_eff = tcce_pkg::RowsCfgWidth'(1);
      end
      if (rows_eff > tcce_pkg::RowsCfgWidth'(tcce_pkg::RowLimit)) begin
         rows_eff = tcce_pkg::RowsCfgWidth'(tcce_pkg::RowLimit);
      end
      rows_m1 = RowW'(rows_eff - tcce_pkg::RowsCfgWidth'(1));
      cols_eff = {1'b0, columns_in_use_ff};
      if (cols_eff > (ColW + 1)'(tcce_pkg::MaxColumns)) begin
         cols_eff = (ColW + 1)'(tcce_pkg::MaxColumns);
      end
   end

   // new line and wrap decisions from the current cursor
   assign wrap      = ({1'b0, cursor_column_ff} + (ColW + 1)'(1)) >= cols_eff;
   assign nl_scroll = !(cursor_row_ff < rows_m1);
   assign nl_row    = nl_scroll ? cursor_row_ff : cursor_row_ff + RowW'(1);
   assign prev_row  = cursor_row_ff - RowW'(1);

   // command list and next state for the byte in the input register
   always_comb begin
      cursor_column_in = cursor_column_ff;
      cursor_row_in    = cursor_row_ff;
      halted_in        = halted_ff;
      scroll           = 1'b0;
      count_in         = '0;
      table_mid        = line_length_ff;
      for (int i = 0; i < tcce_pkg::ResultSlots; i++) begin
         list_in[i] = tcce_pkg::make_result(tcce_pkg::CmdErase, '0, '0, '0);
      end

      if (!halted_ff) begin
         // erase the old cursor at the start of a string
         if (in_first_ff) begin
            list_in[count_in[tcce_pkg::SlotIdxWidth-1:0]] =
               tcce_pkg::make_result(tcce_pkg::CmdErase, cursor_column_ff, cursor_row_ff, '0);
            count_in = count_in + 1'b1;
         end

         if (in_char_ff >= tcce_pkg::CharSpace && in_char_ff <= tcce_pkg::CharTilde) begin
            // printable glyph
            list_in[count_in[tcce_pkg::SlotIdxWidth-1:0]] =
               tcce_pkg::make_result(tcce_pkg::CmdDraw, cursor_column_ff, cursor_row_ff,
                                     in_char_ff[tcce_pkg::GlyphWidth-1:0]);
            count_in = count_in + 1'b1;
            table_mid[cursor_row_ff] = cursor_column_ff;
            if (wrap) begin
               cursor_column_in = '0;
               cursor_row_in    = nl_row;
               scroll           = nl_scroll;
            end else begin
               cursor_column_in = cursor_column_ff + ColW'(1);
            end
         end else if (in_char_ff == tcce_pkg::CharLf || in_char_ff == tcce_pkg::CharCr) begin
            // carriage return and line feed
            cursor_column_in = '0;
            cursor_row_in    = nl_row;
            scroll           = nl_scroll;
         end else if (in_char_ff == tcce_pkg::CharDelete) begin
            // step back, across rows through the line length table
            if (cursor_column_ff != '0) begin
               cursor_column_in         = cursor_column_ff - ColW'(1);
               table_mid[cursor_row_ff] = cursor_column_ff - ColW'(1);
            end else if (cursor_row_ff != '0) begin
               table_mid[cursor_row_ff] = '0;
               cursor_row_in            = prev_row;
               cursor_column_in         = line_length_ff[prev_row];
            end
            list_in[count_in[tcce_pkg::SlotIdxWidth-1:0]] =
               tcce_pkg::make_result(tcce_pkg::CmdErase, cursor_column_in, cursor_row_in, '0);
            count_in = count_in + 1'b1;
         end else begin
            // unsupported code halts the block
            list_in[count_in[tcce_pkg::SlotIdxWidth-1:0]] =
               tcce_pkg::make_result(tcce_pkg::CmdError, cursor_column_ff, cursor_row_ff, '0);
            count_in  = count_in + 1'b1;
            halted_in = 1'b1;
         end

         // scroll up one row at the bottom
         if (scroll) begin
            list_in[count_in[tcce_pkg::SlotIdxWidth-1:0]] =
               tcce_pkg::make_result(tcce_pkg::CmdScroll, '0, rows_m1, '0);
            count_in = count_in + 1'b1;
         end

         // cursor after the last byte of a string
         if (in_last_ff && !halted_in) begin
            list_in[count_in[tcce_pkg::SlotIdxWidth-1:0]] =
               tcce_pkg::make_result(tcce_pkg::CmdDraw, cursor_column_in, cursor_row_in,
                                     tcce_pkg::CursorGlyph);
            count_in = count_in + 1'b1;
         end
      end

      // line length table, shifted up one row on a scroll
      for (int i = 0; i < tcce_pkg::TableDepth; i++) begin
         line_length_in[i] = table_mid[i];
         if (scroll) begin
            if (i == int'(rows_m1)) begin
               line_length_in[i] = '0;
            end else if (i < int'(rows_m1)) begin
               line_length_in[i] = table_mid[(i + 1) % tcce_pkg::TableDepth];
            end
         end
      end
   end

   // valid next state for the input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_in_use_ff <= tcce_pkg::ColumnsReset;
         rows_in_use_ff    <= tcce_pkg::RowsReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tcce_pkg::RegColumns: columns_in_use_ff <= csr_write_data[ColW-1:0];
            tcce_pkg::RegRows:    rows_in_use_ff    <= csr_write_data[tcce_pkg::RowsCfgWidth-1:0];
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff  <= req_char_code;
         in_first_ff <= req_first_of_string;
         in_last_ff  <= req_last_of_string;
      end
   end

   // console state
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_column_ff <= '0;
         cursor_row_ff    <= '0;
         halted_ff        <= 1'b0;
         for (int i = 0; i < tcce_pkg::TableDepth; i++) begin
            line_length_ff[i] <= '0;
         end
      end else if (move) begin
         cursor_column_ff <= cursor_column_in;
         cursor_row_ff    <= cursor_row_in;
         halted_ff        <= halted_in;
         line_length_ff   <= line_length_in;
      end
   end

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_idx_ff   <= '0;
      end else if (move) begin
         rsp_valid_ff <= (count_in != '0);
         rsp_idx_ff   <= '0;
      end else if (rsp_take) begin
         rsp_valid_ff <= (rsp_idx_ff != rsp_last_ff);
         rsp_idx_ff   <= rsp_idx_ff + 1'b1;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (move) begin
         rsp_list_ff <= list_in;
         rsp_last_ff <= tcce_pkg::SlotIdxWidth'(count_in - 1'b1);
      end
   end

   // outputs
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_command     = rsp_list_ff[rsp_idx_ff].command;
   assign rsp_column      = rsp_list_ff[rsp_idx_ff].column;
   assign rsp_row         = rsp_list_ff[rsp_idx_ff].row;
   assign rsp_glyph       = rsp_list_ff[rsp_idx_ff].glyph;
   assign rsp_last_result = (rsp_idx_ff == rsp_last_ff);

   // checks
   `ASSERT_CLK(a_halt_no_output, !(halted_ff && move && count_in != '0), "halted output")
   `ASSERT_NEXT(a_batch_holds, rsp_take && !rsp_last_result, rsp_valid, "list cut short")
   `ASSERT_CLK(a_error_is_last, !(rsp_valid && rsp_command == tcce_pkg::CmdError) || rsp_last_result, "error not final")

endmodule

`default_nettype wire
